### rtl/core/msp_pkg.sv
// msp_pkg: types, codes and the property lookup for the mesh sensor status parser
// no dependencies; used by the channel interfaces, the parser and its checker
package msp_pkg;

  // value bytes kept per record, capped at the 32-bit sample field
  localparam int VALUE_BYTES = 4;
  localparam int ACC_BYTES   = (VALUE_BYTES < 4) ? VALUE_BYTES : 4;

  // header masks
  localparam logic [7:0] HDR_FMT_MASK  = 8'h01;
  localparam logic [7:0] HDR_LENA_MASK = 8'h1E;
  localparam logic [7:0] HDR_IDA_MASK  = 8'hE0;
  localparam logic [7:0] HDR_LENB_MASK = 8'hFE;

  typedef enum logic [1:0] {
    PH_HDR0  = 2'd0,
    PH_HDR1  = 2'd1,
    PH_HDR2  = 2'd2,
    PH_VALUE = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    KIND_PRESENCE = 3'd0,
    KIND_LIGHT    = 3'd1,
    KIND_POWER    = 3'd2,
    KIND_CURRENT  = 3'd3,
    KIND_VOLTAGE  = 3'd4,
    KIND_ENERGY   = 3'd5,
    KIND_PRECISE  = 3'd6,
    KIND_UNKNOWN  = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNKNOWN  = 2'd1,
    ST_LEN_BAD  = 2'd2,
    ST_TRUNC    = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] source_address;
    logic        message_end;
  } in_word_t;

  typedef struct packed {
    logic [15:0] prop_id;
    logic [2:0]  prop_kind;
    logic [31:0] sample_value;
    logic [7:0]  value_length;
    logic [1:0]  record_status;
    logic [15:0] sender;
  } out_word_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] expect_len;
  } prop_info_t;

  function automatic prop_info_t prop_lookup(input logic [15:0] id);
    prop_info_t r;
    unique case (id)
      16'h004D: r = '{KIND_PRESENCE, 8'd1};
      16'h004E: r = '{KIND_LIGHT,    8'd3};
      16'h0052: r = '{KIND_POWER,    8'd3};
      16'h0057: r = '{KIND_CURRENT,  8'd2};
      16'h0059: r = '{KIND_VOLTAGE,  8'd2};
      16'h006A: r = '{KIND_ENERGY,   8'd3};
      16'h0072: r = '{KIND_PRECISE,  8'd4};
      default:  r = '{KIND_UNKNOWN,  8'd0};
    endcase
    return r;
  endfunction

endpackage

### rtl/core/msp_if.sv
// msp channel interfaces: payload byte channel and record channel
// depends on msp_pkg for the word types
interface msp_in_if;
  import msp_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface msp_out_if;
  import msp_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/mesh_sensor_status_parser.sv
// mesh sensor status parser: splits a sensor status payload into records
// depends on msp_pkg and the msp_in_if / msp_out_if channel interfaces
//
//   channel  dir  word                                           handshake
//   rx       in   data_byte, source_address, message_end         valid/ready
//   tx       out  prop_id, prop_kind, sample_value, value_length, valid/ready
//                 record_status, sender
//
// one byte per cycle while rx.ready is high; a record word is registered into
// tx from the byte that ends it. header/length state updates with the byte.
// rst (synchronous) returns the parser to the first header byte and empties tx.
// a two-entry output stage (register plus skid) lets rx keep flowing for one
// word of tx stall; rx.ready drops only while the skid entry is occupied.
module mesh_sensor_status_parser
  import msp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  msp_in_if.sink        rx,
  msp_out_if.source     tx
);

  phase_t      phase, phase_next;
  logic        long_format, long_format_next;
  logic [15:0] pending_id, pending_id_next;
  logic [7:0]  decl_len, decl_len_next;
  logic [7:0]  bytes_seen, bytes_seen_next;
  logic [31:0] acc, acc_next;

  logic        accept;
  logic        done;
  logic        emit;
  out_word_t   rec;
  prop_info_t  info;

  out_word_t   out_word;
  logic        out_valid;
  out_word_t   skid_word;
  logic        skid_valid;
  logic        take;

  assign accept   = rx.valid && rx.ready;
  assign take     = tx.valid && tx.ready;
  assign rx.ready = !skid_valid;
  assign tx.valid = out_valid;
  assign tx.data  = out_word;

  // next parse phase
  always_comb begin
    unique case (phase)
      PH_HDR0:  phase_next = PH_HDR1;
      PH_HDR1:  phase_next = long_format ? PH_HDR2 : PH_VALUE;
      PH_HDR2:  phase_next = PH_VALUE;
      PH_VALUE: phase_next = PH_VALUE;
      default:  phase_next = PH_HDR0;
    endcase
  end

  // record fields after this byte
  always_comb begin
    long_format_next = long_format;
    pending_id_next  = pending_id;
    decl_len_next    = decl_len;
    bytes_seen_next  = bytes_seen;
    acc_next         = acc;
    done             = 1'b0;
    unique case (phase)
      PH_HDR0: begin
        acc_next        = '0;
        bytes_seen_next = '0;
        if ((rx.data.data_byte & HDR_FMT_MASK) != 8'd0) begin
          long_format_next = 1'b1;
          decl_len_next    = ((rx.data.data_byte & HDR_LENB_MASK) >> 1) + 8'd1;
          pending_id_next  = '0;
        end else begin
          long_format_next = 1'b0;
          decl_len_next    = ((rx.data.data_byte & HDR_LENA_MASK) >> 1) + 8'd1;
          pending_id_next  = {8'd0, (rx.data.data_byte & HDR_IDA_MASK) >> 5};
        end
      end
      PH_HDR1: begin
        if (long_format) begin
          pending_id_next = {8'd0, rx.data.data_byte};
        end else begin
          pending_id_next = {5'd0, rx.data.data_byte, pending_id[2:0]};
        end
      end
      PH_HDR2: begin
        pending_id_next = {rx.data.data_byte, pending_id[7:0]};
      end
      PH_VALUE: begin
        for (int k = 0; k < ACC_BYTES; k++) begin
          if (bytes_seen == 8'(k)) acc_next[8*k +: 8] = rx.data.data_byte;
        end
        bytes_seen_next = bytes_seen + 8'd1;
        done            = (bytes_seen_next >= decl_len);
      end
      default: begin
        done = 1'b0;
      end
    endcase
  end

  // result word for a record that ends on this byte
  always_comb begin
    info              = prop_lookup(pending_id_next);
    emit              = accept && (done || rx.data.message_end);
    rec.prop_id       = pending_id_next;
    rec.prop_kind     = info.kind;
    rec.sample_value  = acc_next;
    rec.value_length  = decl_len_next;
    rec.sender        = rx.data.source_address;
    priority if (!done) begin
      rec.record_status = ST_TRUNC;
    end else if (info.kind == KIND_UNKNOWN) begin
      rec.record_status = ST_UNKNOWN;
    end else if (decl_len_next != info.expect_len) begin
      rec.record_status = ST_LEN_BAD;
    end else begin
      rec.record_status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HDR0;
      long_format <= 1'b0;
      pending_id  <= '0;
      decl_len    <= '0;
      bytes_seen  <= '0;
      acc         <= '0;
    end else if (accept) begin
      if (emit) begin
        phase       <= PH_HDR0;
        long_format <= 1'b0;
        pending_id  <= '0;
        decl_len    <= '0;
        bytes_seen  <= '0;
        acc         <= '0;
      end else begin
        phase       <= phase_next;
        long_format <= long_format_next;
        pending_id  <= pending_id_next;
        decl_len    <= decl_len_next;
        bytes_seen  <= bytes_seen_next;
        acc         <= acc_next;
      end
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= emit;
      end
    end else if (emit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      if (skid_valid) begin
        out_word <= skid_word;
      end else if (emit) begin
        out_word <= rec;
      end
    end else if (emit) begin
      skid_word <= rec;
    end
  end

endmodule

### rtl/core/msp_checker.sv
// msp_checker: port-level assertions for the mesh sensor status parser
// depends on msp_pkg; bound to mesh_sensor_status_parser at the end of this file
module msp_checker
  import msp_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_word
);

  prop_info_t info;
  assign info = prop_lookup(out_word.prop_id);

  // a stalled word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("record word changed while stalled");

  // a complete record carries the kind that its id maps to
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.record_status != ST_TRUNC |->
      out_word.prop_kind == info.kind)
    else $error("kind does not match property id");

  // ok only for a known property with its expected length
  a_ok_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.record_status == ST_OK |->
      info.kind != KIND_UNKNOWN && out_word.value_length == info.expect_len)
    else $error("ok status on unknown property or wrong length");

  // declared length is never zero
  a_len_nz: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word.value_length != 8'd0)
    else $error("zero value length in record");

  // input is stalled only while a word is waiting on the output
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

endmodule

bind mesh_sensor_status_parser msp_checker u_msp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (rx.ready),
  .out_valid (tx.valid),
  .out_ready (tx.ready),
  .out_word  (tx.data)
);
